// ===== sv/gn2_pkg.sv =====
// Shared constants, types and hash helpers for the 2D gradient noise block.
// No dependencies; used by gradient_noise_2d.
package gn2_pkg;

	// Output field width
	localparam int OUT_W = 18;

	// Lattice corner hash
	typedef logic [31:0] hash_t;
	typedef logic [1:0]  grad_sel_t;

	localparam hash_t HASH_MUL_X   = 32'd374761393;
	localparam hash_t HASH_MUL_Z   = 32'd668265263;
	localparam hash_t HASH_MUL_MIX = 32'd1274126177;
	localparam int    HASH_SHIFT   = 13;

	// Diagonal gradient codes (low two hash bits)
	localparam grad_sel_t GRAD_PP = 2'd0; //  dx + dz
	localparam grad_sel_t GRAD_NP = 2'd1; // -dx + dz
	localparam grad_sel_t GRAD_PN = 2'd2; //  dx - dz
	localparam grad_sel_t GRAD_NN = 2'd3; // -dx - dz

	// Fold the high bits down with a sign-filling shift
	function automatic hash_t hash_mix(input hash_t h);
		hash_mix = h ^ hash_t'($signed(h) >>> HASH_SHIFT);
	endfunction

	// Low two bits of the final multiply depend only on the low two bits of its factors
	function automatic grad_sel_t hash_sel(input hash_t hs);
		hash_sel = grad_sel_t'(hs[1:0] * HASH_MUL_MIX[1:0]);
	endfunction

endpackage

// ===== sv/gradient_noise_2d.sv =====
// 2D gradient noise: six-stage pipeline from lattice hash and fade curve to final blend.
// Depends on gn2_pkg (hash constants, gradient codes, hash helpers).

// One point enters per clock whenever busy is low, and busy is low at all times except
// during reset and until the ready register is set after it. Each result appears on
// noise_value for one cycle with done high, after the stage registers and the output
// register, in request order. There is no backpressure on the result side: the receiver
// must take every result as it comes. The latency is set by the fade curve, three dependent
// multiplies, followed by the two dependent blend multiplies, each with its own register stage.
module gradient_noise_2d #(
	parameter int FRAC_BITS    = 16,
	parameter int LATTICE_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [31:0]         x_coord,
	input  logic signed [31:0]         z_coord,
	output logic                       done,
	output logic signed [gn2_pkg::OUT_W-1:0] noise_value
);

	localparam int F   = FRAC_BITS;
	localparam int L   = LATTICE_BITS;
	localparam int UW  = F + 1;        // fade weight, 0 to one
	localparam int MW  = F + 4;        // fade inner terms
	localparam int GW  = F + 3;        // corner gradient
	localparam int DW  = F + 4;        // corner difference and row blend
	localparam int EW  = F + 5;        // row difference
	localparam int P0W = 2 * F + 6;    // row blend product
	localparam int P1W = 2 * F + 7;    // column blend product
	localparam int RW  = (F + 6 > gn2_pkg::OUT_W) ? F + 6 : gn2_pkg::OUT_W;

	localparam logic [MW-1:0] FIFTEEN = MW'(15) << F;
	localparam logic [MW-1:0] TEN     = MW'(10) << F;
	localparam logic [GW-1:0] ONE_G   = GW'(1) << F;
	localparam logic [RW-1:0] ONE_R   = RW'(1) << F;
	localparam int            G_MAX   = 2 << F;

	// Gradient dot product for one corner
	function automatic logic [GW-1:0] grad(input gn2_pkg::grad_sel_t sel,
			input logic [GW-1:0] dx, input logic [GW-1:0] dz);
		unique case (sel)
			gn2_pkg::GRAD_PP: grad = dx + dz;
			gn2_pkg::GRAD_NP: grad = dz - dx;
			gn2_pkg::GRAD_PN: grad = dx - dz;
			gn2_pkg::GRAD_NN: grad = GW'(0) - dx - dz;
			default:          grad = dx + dz;
		endcase
	endfunction

	logic ready_q;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic done_q;
	logic [gn2_pkg::OUT_W-1:0] noise_q;

	// ------------------------------------------------------------------
	// Stage 1: split coordinates into cell and fraction
	// ------------------------------------------------------------------
	logic [31+L:0] xe, ze;
	logic [L-1:0]  cx_s1, cz_s1;
	logic [F-1:0]  xf_s1, zf_s1;

	assign accept = start && !busy;
	assign xe     = {{L{x_coord[31]}}, x_coord};
	assign ze     = {{L{z_coord[31]}}, z_coord};

	// Capture request
	always_ff @(posedge clk) begin
		cx_s1 <= xe[F +: L];
		cz_s1 <= ze[F +: L];
		xf_s1 <= x_coord[F-1:0];
		zf_s1 <= z_coord[F-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 1 -> 2: fade first products, hash coordinate products
	// ------------------------------------------------------------------
	logic [MW-1:0]      mx, mz;
	logic [2*F-1:0]     ttx, ttz;
	logic [2*F+3:0]     tmx, tmz;
	gn2_pkg::hash_t     cxa, cxb, cza, czb;
	gn2_pkg::hash_t     pxa, pxb, pza, pzb;

	assign mx  = FIFTEEN - {2'b00, xf_s1, 2'b00} - {3'b000, xf_s1, 1'b0};
	assign mz  = FIFTEEN - {2'b00, zf_s1, 2'b00} - {3'b000, zf_s1, 1'b0};
	assign ttx = xf_s1 * xf_s1;
	assign ttz = zf_s1 * zf_s1;
	assign tmx = xf_s1 * mx;
	assign tmz = zf_s1 * mz;

	// Corner coordinates are not wrapped: X+1 may reach the lattice size
	assign cxa = {{(32-L){1'b0}}, cx_s1};
	assign cza = {{(32-L){1'b0}}, cz_s1};
	assign cxb = cxa + 32'd1;
	assign czb = cza + 32'd1;
	assign pxa = cxa * gn2_pkg::HASH_MUL_X;
	assign pxb = cxb * gn2_pkg::HASH_MUL_X;
	assign pza = cza * gn2_pkg::HASH_MUL_Z;
	assign pzb = czb * gn2_pkg::HASH_MUL_Z;

	logic [2*F-1:0]  ttx_s2, ttz_s2;
	logic [2*F+3:0]  tmx_s2, tmz_s2;
	logic [F-1:0]    xf_s2, zf_s2;
	gn2_pkg::hash_t  pxa_s2, pxb_s2, pza_s2, pzb_s2;

	always_ff @(posedge clk) begin
		ttx_s2 <= ttx;
		ttz_s2 <= ttz;
		tmx_s2 <= tmx;
		tmz_s2 <= tmz;
		xf_s2  <= xf_s1;
		zf_s2  <= zf_s1;
		pxa_s2 <= pxa;
		pxb_s2 <= pxb;
		pza_s2 <= pza;
		pzb_s2 <= pzb;
	end

	// ------------------------------------------------------------------
	// Stage 2 -> 3: fade inner term and cube, corner hash mixing
	// ------------------------------------------------------------------
	logic [MW-1:0]   innerx, innerz;
	logic [2*F-1:0]  t3px, t3pz;
	gn2_pkg::hash_t  hs00, hs10, hs01, hs11;

	// t*(6t - 15) is never positive, so truncation is one subtract of the magnitude
	assign innerx = TEN - tmx_s2[2*F+3:F];
	assign innerz = TEN - tmz_s2[2*F+3:F];
	assign t3px   = ttx_s2[2*F-1:F] * xf_s2;
	assign t3pz   = ttz_s2[2*F-1:F] * zf_s2;
	assign hs00   = gn2_pkg::hash_mix(pxa_s2 + pza_s2);
	assign hs10   = gn2_pkg::hash_mix(pxb_s2 + pza_s2);
	assign hs01   = gn2_pkg::hash_mix(pxa_s2 + pzb_s2);
	assign hs11   = gn2_pkg::hash_mix(pxb_s2 + pzb_s2);

	logic [MW-1:0]   innerx_s3, innerz_s3;
	logic [2*F-1:0]  t3px_s3, t3pz_s3;
	logic [F-1:0]    xf_s3, zf_s3;
	gn2_pkg::hash_t  hs00_s3, hs10_s3, hs01_s3, hs11_s3;

	always_ff @(posedge clk) begin
		innerx_s3 <= innerx;
		innerz_s3 <= innerz;
		t3px_s3   <= t3px;
		t3pz_s3   <= t3pz;
		xf_s3     <= xf_s2;
		zf_s3     <= zf_s2;
		hs00_s3   <= hs00;
		hs10_s3   <= hs10;
		hs01_s3   <= hs01;
		hs11_s3   <= hs11;
	end

	// ------------------------------------------------------------------
	// Stage 3 -> 4: fade product, gradient selection
	// ------------------------------------------------------------------
	logic [2*F+3:0]  fadepx, fadepz;
	logic [GW-1:0]   dx0, dx1, dz0, dz1;
	logic [GW-1:0]   g00, g10, g01, g11;

	assign fadepx = t3px_s3[2*F-1:F] * innerx_s3;
	assign fadepz = t3pz_s3[2*F-1:F] * innerz_s3;
	assign dx0    = {3'b000, xf_s3};
	assign dz0    = {3'b000, zf_s3};
	assign dx1    = dx0 - ONE_G;
	assign dz1    = dz0 - ONE_G;
	assign g00    = grad(gn2_pkg::hash_sel(hs00_s3), dx0, dz0);
	assign g10    = grad(gn2_pkg::hash_sel(hs10_s3), dx1, dz0);
	assign g01    = grad(gn2_pkg::hash_sel(hs01_s3), dx0, dz1);
	assign g11    = grad(gn2_pkg::hash_sel(hs11_s3), dx1, dz1);

	logic [2*F+3:0]  fadepx_s4, fadepz_s4;
	logic [GW-1:0]   g00_s4, g10_s4, g01_s4, g11_s4;

	always_ff @(posedge clk) begin
		fadepx_s4 <= fadepx;
		fadepz_s4 <= fadepz;
		g00_s4    <= g00;
		g10_s4    <= g10;
		g01_s4    <= g01;
		g11_s4    <= g11;
	end

	// ------------------------------------------------------------------
	// Stage 4 -> 5: horizontal blend products
	// ------------------------------------------------------------------
	logic [UW-1:0]          uf, vf;
	logic [DW-1:0]          d0, d1;
	logic signed [P0W-1:0]  p0, p1;

	assign uf = fadepx_s4[2*F:F];
	assign vf = fadepz_s4[2*F:F];
	assign d0 = {g10_s4[GW-1], g10_s4} - {g00_s4[GW-1], g00_s4};
	assign d1 = {g11_s4[GW-1], g11_s4} - {g01_s4[GW-1], g01_s4};
	assign p0 = $signed({1'b0, uf}) * $signed(d0);
	assign p1 = $signed({1'b0, uf}) * $signed(d1);

	logic signed [P0W-1:0]  p0_s5, p1_s5;
	logic [GW-1:0]          g00_s5, g01_s5;
	logic [UW-1:0]          vf_s5;

	always_ff @(posedge clk) begin
		p0_s5  <= p0;
		p1_s5  <= p1;
		g00_s5 <= g00_s4;
		g01_s5 <= g01_s4;
		vf_s5  <= vf;
	end

	// ------------------------------------------------------------------
	// Stage 5 -> 6: finish rows, vertical blend product
	// ------------------------------------------------------------------
	logic [P0W-1:0]         adj0, adj1;
	logic [DW-1:0]          row0, row1;
	logic [EW-1:0]          rd;
	logic signed [P1W-1:0]  pr;

	// Truncate toward zero: bias negative products before dropping fraction bits
	assign adj0 = p0_s5 + {{(P0W-F){1'b0}}, {F{p0_s5[P0W-1]}}};
	assign adj1 = p1_s5 + {{(P0W-F){1'b0}}, {F{p1_s5[P0W-1]}}};
	assign row0 = {g00_s5[GW-1], g00_s5} + adj0[F+DW-1:F];
	assign row1 = {g01_s5[GW-1], g01_s5} + adj1[F+DW-1:F];
	assign rd   = {row1[DW-1], row1} - {row0[DW-1], row0};
	assign pr   = $signed({1'b0, vf_s5}) * $signed(rd);

	logic signed [P1W-1:0]  pr_s6;
	logic [DW-1:0]          row0_s6;

	always_ff @(posedge clk) begin
		pr_s6   <= pr;
		row0_s6 <= row0;
	end

	// ------------------------------------------------------------------
	// Stage 6 -> out: final blend, offset and halve toward zero
	// ------------------------------------------------------------------
	logic [P1W-1:0]  adj2;
	logic [EW-1:0]   col;
	logic [RW-1:0]   res, res_adj, half;

	assign adj2    = pr_s6 + {{(P1W-F){1'b0}}, {F{pr_s6[P1W-1]}}};
	assign col     = adj2[F+EW-1:F];
	assign res     = {{(RW-DW){row0_s6[DW-1]}}, row0_s6}
	               + {{(RW-EW){col[EW-1]}}, col} + ONE_R;
	assign res_adj = res + {{(RW-1){1'b0}}, res[RW-1]};
	assign half    = {res_adj[RW-1], res_adj[RW-1:1]};

	always_ff @(posedge clk) begin
		noise_q <= half[gn2_pkg::OUT_W-1:0];
	end

	// ------------------------------------------------------------------
	// Valid chain and request gate
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			done_q  <= v_s6;
		end
	end

	assign busy        = !ready_q;
	assign done        = done_q;
	assign noise_value = $signed(noise_q);

`ifndef NO_ASSERTIONS
	// Every request yields a result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("result missing after request");

	// No result without a matching earlier request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("result without request");

	// Once ready, the block never stalls requests again
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

	// Corner gradients g00 and g11 stay within plus or minus two
	a_grad_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($signed(g00_s4) <= G_MAX && $signed(g00_s4) >= -G_MAX
			&& $signed(g11_s4) <= G_MAX && $signed(g11_s4) >= -G_MAX))
		else $error("corner gradient out of range");
`endif

endmodule
